>>> sv/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

  // Field widths
  localparam int COMP_W = 8;
  localparam int HUE_W  = 12;
  localparam int SAT_W  = 13;
  localparam int FRAC_W = 12;

  // Hue divisor is six times the spread, at most 6*255
  localparam int HDIV_W = 11;

  // Number of quotient cells in the chain, one fraction bit each
  localparam int NUM_CELLS = FRAC_W;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rhc_pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [COMP_W-1:0] brightness;
  } rhc_hsv_t;

  // Data carried from one cell to the next
  typedef struct packed {
    logic              valid;
    logic [COMP_W-1:0] bright;
    logic [COMP_W-1:0] sat_rem;
    logic [COMP_W-1:0] sat_div;
    logic [SAT_W-1:0]  sat_quo;
    logic [HDIV_W-1:0] hue_rem;
    logic [HDIV_W-1:0] hue_div;
    logic [HUE_W-1:0]  hue_quo;
  } rhc_stage_t;

endpackage

`default_nettype wire

>>> sv/rhc_front.sv
`default_nettype none

module rhc_front import rhc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire rhc_pixel_t pixel,
  output rhc_stage_t      stage_o
);

  localparam int NUM_W = HDIV_W;

  logic [COMP_W-1:0] r, g, b;
  logic [COMP_W-1:0] mx, mn, delta;
  logic              red_max, green_max;
  logic [NUM_W-1:0]  d_ext, six_d, num;
  logic              sat_int;
  rhc_stage_t        stage_nxt;
  logic              valid_r;
  rhc_stage_t        stage_r;

  assign r = pixel.red;
  assign g = pixel.green;
  assign b = pixel.blue;

  // Pick the largest component: red wins ties, then green
  always_comb begin
    red_max   = (r >= g) && (r >= b);
    green_max = !red_max && (g >= b);
    if (red_max) begin
      mx = r;
    end else if (green_max) begin
      mx = g;
    end else begin
      mx = b;
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
  end

  // Hue numerator k*delta + diff, known to lie in [0, 6*delta)
  always_comb begin
    d_ext = NUM_W'(delta);
    six_d = (d_ext << 2) + (d_ext << 1);
    if (red_max) begin
      if (g >= b) begin
        num = NUM_W'(g) - NUM_W'(b);
      end else begin
        num = six_d + NUM_W'(g) - NUM_W'(b);
      end
    end else if (green_max) begin
      num = (d_ext << 1) + NUM_W'(b) - NUM_W'(r);
    end else begin
      num = (d_ext << 2) + NUM_W'(r) - NUM_W'(g);
    end
  end

  // Seed both division lanes; a zero divisor becomes one over a zero remainder
  always_comb begin
    sat_int             = (delta == mx) && (mx != '0);
    stage_nxt.valid     = take;
    stage_nxt.bright    = mx;
    stage_nxt.sat_div   = (mx == '0) ? COMP_W'(1) : mx;
    stage_nxt.sat_rem   = sat_int ? '0 : delta;
    stage_nxt.sat_quo   = SAT_W'(sat_int);
    stage_nxt.hue_div   = (delta == '0) ? HDIV_W'(1) : six_d[HDIV_W-1:0];
    stage_nxt.hue_rem   = num[HDIV_W-1:0];
    stage_nxt.hue_quo   = '0;
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
  end

  // Advance payload every cycle
  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  always_comb begin
    stage_o       = stage_r;
    stage_o.valid = valid_r;
  end

endmodule

`default_nettype wire

>>> sv/rhc_cell.sv
`default_nettype none

module rhc_cell import rhc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rhc_stage_t stage_i,
  output rhc_stage_t      stage_o
);

  logic [COMP_W:0]   sat_sh;
  logic              sat_ge;
  logic [HDIV_W:0]   hue_sh;
  logic              hue_ge;
  rhc_stage_t        stage_nxt;
  logic              valid_r;
  rhc_stage_t        stage_r;

  // Develop one quotient bit in each lane by shift, compare and subtract
  always_comb begin
    sat_sh = {stage_i.sat_rem, 1'b0};
    sat_ge = sat_sh >= {1'b0, stage_i.sat_div};
    hue_sh = {stage_i.hue_rem, 1'b0};
    hue_ge = hue_sh >= {1'b0, stage_i.hue_div};

    stage_nxt         = stage_i;
    stage_nxt.sat_rem = sat_ge ? COMP_W'(sat_sh - {1'b0, stage_i.sat_div})
                               : sat_sh[COMP_W-1:0];
    stage_nxt.sat_quo = {stage_i.sat_quo[SAT_W-2:0], sat_ge};
    stage_nxt.hue_rem = hue_ge ? HDIV_W'(hue_sh - {1'b0, stage_i.hue_div})
                               : hue_sh[HDIV_W-1:0];
    stage_nxt.hue_quo = {stage_i.hue_quo[HUE_W-2:0], hue_ge};
  end

  // Clear the valid flag on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_i.valid;
    end
  end

  // Hand payload to the next cell
  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  always_comb begin
    stage_o       = stage_r;
    stage_o.valid = valid_r;
  end

endmodule

`default_nettype wire

>>> sv/rgb_to_hsv_converter.sv
// Pipeline: one setup stage, then twelve divide cells, each adding one
// fraction bit of hue and of saturation, with every stage registered.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// Reset (rst_n low, synchronous) clears all valid flags; no item in flight
// survives it. The receiver cannot stall: each result shows for one cycle.
`default_nettype none

module rgb_to_hsv_converter import rhc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire rhc_pixel_t in_pixel,
  output logic            out_valid,
  output rhc_hsv_t        out_hsv
);

  rhc_stage_t chain [NUM_CELLS+1];

  // The chain never blocks
  assign busy = 1'b0;

  rhc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (start && !busy),
    .pixel   (in_pixel),
    .stage_o (chain[0])
  );

  // Row of divide cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // Drive the result straight from the last cell's registers
  assign out_valid          = chain[NUM_CELLS].valid;
  assign out_hsv.hue        = chain[NUM_CELLS].hue_quo;
  assign out_hsv.saturation = chain[NUM_CELLS].sat_quo;
  assign out_hsv.brightness = chain[NUM_CELLS].bright;

endmodule

`default_nettype wire
